// File: design/fatlb_pkg.sv
// ============================================================================
// fatlb_pkg
// Shared types and constants for the fully associative TLB with LRU order.
// ============================================================================
package fatlb_pkg;

    // Geometry of the entry array.
    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int RANK_W      = $clog2(NUM_ENTRIES);
    localparam int ACT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int PAGE_W      = 24;
    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_PAGES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'b1;

    // Page geometry.
    localparam int SMALL_SHIFT = 8;
    localparam int LARGE_SHIFT = 12;
    localparam logic [PAGE_W-1:0] SMALL_MISS_MASK = 24'hFFF0FF;
    localparam logic [PAGE_W-1:0] LARGE_MISS_MASK = 24'h0FFF0F;

    // Input transaction.
    typedef struct packed {
        logic [ADDR_W-1:0] virtual_address;
        logic              is_data;
    } req_t;

    // Result transaction.
    typedef struct packed {
        logic              tlb_hit;
        logic [PAGE_W-1:0] physical_page;
        logic [ADDR_W-1:0] phys_addr;
        logic [CNT_W-1:0]  instr_hit_count;
        logic [CNT_W-1:0]  instr_miss_count;
        logic [CNT_W-1:0]  data_hit_count;
        logic [CNT_W-1:0]  data_miss_count;
    } rsp_t;

    // Search token that walks down the row of entry cells.
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic [PAGE_W-1:0] hit_ppage;
        logic              found_inv;
        logic [IDX_W-1:0]  inv_idx;
        logic [RANK_W-1:0] inv_rank;
        logic              lru_seen;
        logic [IDX_W-1:0]  lru_idx;
        logic [RANK_W-1:0] lru_rank;
    } tok_t;

    // Update broadcast to every cell when a lookup commits.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  touch_idx;
        logic [RANK_W-1:0] old_rank;
        logic              write;
        logic [PAGE_W-1:0] vpage;
        logic [PAGE_W-1:0] ppage;
    } upd_t;

endpackage

// File: design/fully_associative_tlb_lru.sv
// Flow: an accepted transaction is registered in start_reg, its search token walks the
// token registers of the entry cells one cell per cycle into pend_tok_reg and waits for
// the commit, and the result is registered in the output register. The next lookup is
// accepted after that commit and searches while the result waits; a stall delays its commit.
// Reset: all entries invalid, entry i has recency rank i, counters zero,
// 256-byte pages and all 16 entries in use.
// ============================================================================
// fully_associative_tlb_lru
// Fully associative TLB with true LRU replacement, built as a row of entry
// cells searched by a token, with hit and miss counters per access kind.
// ============================================================================
module fully_associative_tlb_lru
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [fatlb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fatlb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  fatlb_pkg::req_t                      req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output fatlb_pkg::rsp_t                      rsp
);

    localparam int N = fatlb_pkg::NUM_ENTRIES;

    // Configuration registers.
    logic                              large_pages_reg;
    logic [fatlb_pkg::CFG_DATA_W-1:0]  entries_reg;
    logic [fatlb_pkg::ACT_W-1:0]       active_count;

    // Request and control state.
    logic                              busy_reg;
    logic                              start_reg;
    logic                              pending_reg;
    fatlb_pkg::tok_t                   pend_tok_reg;
    logic [fatlb_pkg::PAGE_W-1:0]      vpage_reg;
    logic [fatlb_pkg::ADDR_W-1:0]      addr_reg;
    logic                              is_data_reg;
    logic                              rsp_valid_reg;
    fatlb_pkg::rsp_t                   rsp_reg, rsp_next;

    // Counters.
    logic [fatlb_pkg::CNT_W-1:0] instr_hits_reg, instr_hits_next;
    logic [fatlb_pkg::CNT_W-1:0] instr_misses_reg, instr_misses_next;
    logic [fatlb_pkg::CNT_W-1:0] data_hits_reg, data_hits_next;
    logic [fatlb_pkg::CNT_W-1:0] data_misses_reg, data_misses_next;

    // Cell row wiring.
    logic [N:0]                    tok_valid;
    fatlb_pkg::tok_t               tok [N+1];
    fatlb_pkg::upd_t               upd;

    logic                          accept;
    logic                          commit;
    logic [fatlb_pkg::PAGE_W-1:0]  req_vpage;
    logic [fatlb_pkg::PAGE_W-1:0]  miss_ppage;
    logic [fatlb_pkg::PAGE_W-1:0]  result_ppage;
    logic [fatlb_pkg::IDX_W-1:0]   miss_idx;
    logic [fatlb_pkg::RANK_W-1:0]  miss_rank;

    assign accept    = req_valid && !busy_reg;
    assign req_stall = busy_reg;
    assign commit    = pending_reg && (!rsp_valid_reg || !rsp_stall);

    // Page number of the incoming address for the current page size.
    assign req_vpage = large_pages_reg
                     ? {{(fatlb_pkg::LARGE_SHIFT - fatlb_pkg::SMALL_SHIFT){1'b0}},
                        req.virtual_address[fatlb_pkg::ADDR_W-1:fatlb_pkg::LARGE_SHIFT]}
                     : req.virtual_address[fatlb_pkg::ADDR_W-1:fatlb_pkg::SMALL_SHIFT];

    // Active entry count, with zero acting as one and large values saturating.
    always_comb
    begin
        if (entries_reg == '0)
        begin
            active_count = fatlb_pkg::ACT_W'(1);
        end
        else if (entries_reg > fatlb_pkg::CFG_DATA_W'(N))
        begin
            active_count = fatlb_pkg::ACT_W'(N);
        end
        else
        begin
            active_count = fatlb_pkg::ACT_W'(entries_reg);
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            large_pages_reg <= 1'b0;
            entries_reg     <= fatlb_pkg::CFG_DATA_W'(16);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fatlb_pkg::REG_LARGE_PAGES:    large_pages_reg <= cfg_data[0];
                fatlb_pkg::REG_ENTRIES_IN_USE: entries_reg     <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Row of entry cells; the token enters at cell 0 in the cycle after accept.
    assign tok_valid[0] = start_reg;
    assign tok[0]       = '0;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        fatlb_cell u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .index         (fatlb_pkg::IDX_W'(g)),
            .active_count  (active_count),
            .lookup_vpage  (vpage_reg),
            .tok_in_valid  (tok_valid[g]),
            .tok_in        (tok[g]),
            .tok_out_valid (tok_valid[g+1]),
            .tok_out       (tok[g+1]),
            .upd           (upd)
        );
    end

    // Miss translation and replacement choice.
    assign miss_ppage = (~vpage_reg) & (large_pages_reg ? fatlb_pkg::LARGE_MISS_MASK
                                                        : fatlb_pkg::SMALL_MISS_MASK);
    assign miss_idx   = pend_tok_reg.found_inv ? pend_tok_reg.inv_idx  : pend_tok_reg.lru_idx;
    assign miss_rank  = pend_tok_reg.found_inv ? pend_tok_reg.inv_rank : pend_tok_reg.lru_rank;
    assign result_ppage = pend_tok_reg.hit ? pend_tok_reg.hit_ppage : miss_ppage;

    // Update broadcast to the cells.
    always_comb
    begin
        upd.en        = commit;
        upd.touch_idx = pend_tok_reg.hit ? pend_tok_reg.hit_idx  : miss_idx;
        upd.old_rank  = pend_tok_reg.hit ? pend_tok_reg.hit_rank : miss_rank;
        upd.write     = !pend_tok_reg.hit;
        upd.vpage     = vpage_reg;
        upd.ppage     = miss_ppage;
    end

    // Counter updates and result assembly.
    always_comb
    begin
        instr_hits_next   = instr_hits_reg;
        instr_misses_next = instr_misses_reg;
        data_hits_next    = data_hits_reg;
        data_misses_next  = data_misses_reg;
        if (commit)
        begin
            if (pend_tok_reg.hit && is_data_reg)
            begin
                data_hits_next = data_hits_reg + 1'b1;
            end
            else if (pend_tok_reg.hit)
            begin
                instr_hits_next = instr_hits_reg + 1'b1;
            end
            else if (is_data_reg)
            begin
                data_misses_next = data_misses_reg + 1'b1;
            end
            else
            begin
                instr_misses_next = instr_misses_reg + 1'b1;
            end
        end

        rsp_next.tlb_hit       = pend_tok_reg.hit;
        rsp_next.physical_page = result_ppage;
        if (large_pages_reg)
        begin
            rsp_next.phys_addr =
                {result_ppage[fatlb_pkg::ADDR_W-fatlb_pkg::LARGE_SHIFT-1:0],
                 addr_reg[fatlb_pkg::LARGE_SHIFT-1:0]};
        end
        else
        begin
            rsp_next.phys_addr =
                {result_ppage[fatlb_pkg::ADDR_W-fatlb_pkg::SMALL_SHIFT-1:0],
                 addr_reg[fatlb_pkg::SMALL_SHIFT-1:0]};
        end
        rsp_next.instr_hit_count  = instr_hits_next;
        rsp_next.instr_miss_count = instr_misses_next;
        rsp_next.data_hit_count   = data_hits_next;
        rsp_next.data_miss_count  = data_misses_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            start_reg        <= 1'b0;
            pending_reg      <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            instr_hits_reg   <= '0;
            instr_misses_reg <= '0;
            data_hits_reg    <= '0;
            data_misses_reg  <= '0;
        end
        else
        begin
            start_reg        <= accept;
            instr_hits_reg   <= instr_hits_next;
            instr_misses_reg <= instr_misses_next;
            data_hits_reg    <= data_hits_next;
            data_misses_reg  <= data_misses_next;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end
            if (tok_valid[N])
            begin
                pending_reg <= 1'b1;
            end
            else if (commit)
            begin
                pending_reg <= 1'b0;
            end
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vpage_reg   <= req_vpage;
            addr_reg    <= req.virtual_address;
            is_data_reg <= req.is_data;
        end
        if (tok_valid[N])
        begin
            pend_tok_reg <= tok[N];
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Only one search token is ever in the row.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tok_valid, pending_reg}))
        else $error("more than one lookup in flight");

    // A search only runs while a transaction is open.
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((|tok_valid) || pending_reg) |-> busy_reg)
        else $error("search token without an open transaction");

    // A commit always leaves a result in the output register.
    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid_reg)
        else $error("commit did not produce a result");

    // Exactly one counter advances on each commit.
    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> $onehot({instr_hits_next != instr_hits_reg,
                            instr_misses_next != instr_misses_reg,
                            data_hits_next != data_hits_reg,
                            data_misses_next != data_misses_reg}))
        else $error("counter update is not exactly one");

endmodule

// File: design/fatlb_cell.sv
// ============================================================================
// fatlb_cell
// One TLB entry: holds valid, page numbers and recency rank, advances the
// search token by one step and applies the commit update.
// ============================================================================
module fatlb_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [fatlb_pkg::IDX_W-1:0]      index,
    input  logic [fatlb_pkg::ACT_W-1:0]      active_count,
    input  logic [fatlb_pkg::PAGE_W-1:0]     lookup_vpage,
    input  logic                             tok_in_valid,
    input  fatlb_pkg::tok_t                  tok_in,
    output logic                             tok_out_valid,
    output fatlb_pkg::tok_t                  tok_out,
    input  fatlb_pkg::upd_t                  upd
);

    logic                          valid_reg, valid_next;
    logic [fatlb_pkg::PAGE_W-1:0]  vpage_reg, vpage_next;
    logic [fatlb_pkg::PAGE_W-1:0]  ppage_reg, ppage_next;
    logic [fatlb_pkg::RANK_W-1:0]  rank_reg, rank_next;
    logic                          tok_valid_reg;
    fatlb_pkg::tok_t               tok_reg, tok_next;
    logic                          active;

    // The entry takes part in the search only below the active count.
    assign active = ({1'b0, index} < active_count);

    // One search step: hit check, first invalid entry, oldest entry.
    always_comb
    begin
        tok_next = tok_in;
        if (active)
        begin
            if (!tok_in.hit && valid_reg && (vpage_reg == lookup_vpage))
            begin
                tok_next.hit       = 1'b1;
                tok_next.hit_idx   = index;
                tok_next.hit_rank  = rank_reg;
                tok_next.hit_ppage = ppage_reg;
            end
            if (!tok_in.found_inv && !valid_reg)
            begin
                tok_next.found_inv = 1'b1;
                tok_next.inv_idx   = index;
                tok_next.inv_rank  = rank_reg;
            end
            if (!tok_in.lru_seen || (rank_reg > tok_in.lru_rank))
            begin
                tok_next.lru_seen = 1'b1;
                tok_next.lru_idx  = index;
                tok_next.lru_rank = rank_reg;
            end
        end
    end

    // Commit update: the touched entry becomes most recent, younger entries age, fill on a miss.
    always_comb
    begin
        valid_next = valid_reg;
        vpage_next = vpage_reg;
        ppage_next = ppage_reg;
        rank_next  = rank_reg;
        if (upd.en)
        begin
            if (upd.touch_idx == index)
            begin
                rank_next = '0;
                if (upd.write)
                begin
                    valid_next = 1'b1;
                    vpage_next = upd.vpage;
                    ppage_next = upd.ppage;
                end
            end
            else if (rank_reg < upd.old_rank)
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    // Entry state; at reset entry i holds rank i.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vpage_reg <= '0;
            ppage_reg <= '0;
            rank_reg  <= index;
        end
        else
        begin
            valid_reg <= valid_next;
            vpage_reg <= vpage_next;
            ppage_reg <= ppage_next;
            rank_reg  <= rank_next;
        end
    end

    // Token register toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in_valid)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the fully associative TLB against a cycle-free model of its lookup,
// fill and LRU update. Directed accesses cover the address extremes, both
// access kinds, the page size switch and the entry count corner values. A
// random part then replays a reused pool of pages so that hits, fills and
// evictions all happen. Both channels idle at random.
// ============================================================================

// Scoreboard: keeps its own copy of the TLB and predicts each translation.
class tlb_scoreboard;
    logic                              large_pages;
    logic [fatlb_pkg::CFG_DATA_W-1:0]  entries_cfg;
    logic                              entry_valid [fatlb_pkg::NUM_ENTRIES];
    logic [fatlb_pkg::PAGE_W-1:0]      entry_vpage [fatlb_pkg::NUM_ENTRIES];
    logic [fatlb_pkg::PAGE_W-1:0]      entry_ppage [fatlb_pkg::NUM_ENTRIES];
    logic [fatlb_pkg::RANK_W-1:0]      entry_rank  [fatlb_pkg::NUM_ENTRIES];
    logic [fatlb_pkg::CNT_W-1:0]       instr_hits;
    logic [fatlb_pkg::CNT_W-1:0]       instr_misses;
    logic [fatlb_pkg::CNT_W-1:0]       data_hits;
    logic [fatlb_pkg::CNT_W-1:0]       data_misses;
    fatlb_pkg::rsp_t                   pending_translations [$];
    int                                mismatches;

    function new();
        large_pages  = 1'b0;
        entries_cfg  = fatlb_pkg::CFG_DATA_W'(fatlb_pkg::NUM_ENTRIES);
        for (int i = 0; i < fatlb_pkg::NUM_ENTRIES; i++)
        begin
            entry_valid[i] = 1'b0;
            entry_vpage[i] = '0;
            entry_ppage[i] = '0;
            entry_rank[i]  = fatlb_pkg::RANK_W'(i);
        end
        instr_hits   = '0;
        instr_misses = '0;
        data_hits    = '0;
        data_misses  = '0;
        mismatches   = 0;
    endfunction

    function void set_register(logic [fatlb_pkg::CFG_IDX_W-1:0] idx,
                               logic [fatlb_pkg::CFG_DATA_W-1:0] val);
        if (idx == fatlb_pkg::REG_LARGE_PAGES)
            large_pages = val[0];
        else if (idx == fatlb_pkg::REG_ENTRIES_IN_USE)
            entries_cfg = val;
    endfunction

    // Make one entry the most recent; younger entries age by one rank.
    function void promote(int e);
        logic [fatlb_pkg::RANK_W-1:0] old_rank;
        old_rank = entry_rank[e];
        for (int i = 0; i < fatlb_pkg::NUM_ENTRIES; i++)
        begin
            if (entry_rank[i] < old_rank)
                entry_rank[i] = entry_rank[i] + 1'b1;
        end
        entry_rank[e] = '0;
    endfunction

    // Work out the translation for an accepted transaction and queue it.
    function void predict_lookup(fatlb_pkg::req_t r);
        int                           shift;
        int                           active;
        int                           slot;
        bit                           hit;
        logic [fatlb_pkg::PAGE_W-1:0] vp;
        logic [fatlb_pkg::PAGE_W-1:0] pp;
        logic [fatlb_pkg::ADDR_W-1:0] off_mask;
        fatlb_pkg::rsp_t              want;
        shift    = large_pages ? fatlb_pkg::LARGE_SHIFT : fatlb_pkg::SMALL_SHIFT;
        off_mask = large_pages ? 32'h0000_0FFF : 32'h0000_00FF;
        vp       = fatlb_pkg::PAGE_W'(r.virtual_address >> shift);
        if (entries_cfg == 0)
            active = 1;
        else if (entries_cfg > fatlb_pkg::NUM_ENTRIES)
            active = fatlb_pkg::NUM_ENTRIES;
        else
            active = int'(entries_cfg);
        hit  = 1'b0;
        slot = -1;
        pp   = '0;

        // Search the active entries in index order.
        for (int i = 0; i < active; i++)
        begin
            if (!hit && entry_valid[i] && entry_vpage[i] == vp)
            begin
                hit  = 1'b1;
                slot = i;
                pp   = entry_ppage[i];
            end
        end

        if (hit)
        begin
            if (r.is_data)
                data_hits = data_hits + 1'b1;
            else
                instr_hits = instr_hits + 1'b1;
            promote(slot);
        end
        else
        begin
            if (r.is_data)
                data_misses = data_misses + 1'b1;
            else
                instr_misses = instr_misses + 1'b1;
            pp = ~vp & (large_pages ? fatlb_pkg::LARGE_MISS_MASK
                                    : fatlb_pkg::SMALL_MISS_MASK);
            // Lowest invalid active entry first, else the oldest active one.
            for (int i = 0; i < active; i++)
            begin
                if (slot < 0 && !entry_valid[i])
                    slot = i;
            end
            if (slot < 0)
            begin
                slot = 0;
                for (int i = 1; i < active; i++)
                begin
                    if (entry_rank[i] > entry_rank[slot])
                        slot = i;
                end
            end
            entry_valid[slot] = 1'b1;
            entry_vpage[slot] = vp;
            entry_ppage[slot] = pp;
            promote(slot);
        end

        want.tlb_hit          = hit;
        want.physical_page    = pp;
        want.phys_addr        = (fatlb_pkg::ADDR_W'(pp) << shift)
                              | (r.virtual_address & off_mask);
        want.instr_hit_count  = instr_hits;
        want.instr_miss_count = instr_misses;
        want.data_hit_count   = data_hits;
        want.data_miss_count  = data_misses;
        pending_translations.push_back(want);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, seen);
            mismatches++;
        end
    endfunction

    // Compare an accepted result with the oldest predicted translation.
    function void check_translation(fatlb_pkg::rsp_t got);
        fatlb_pkg::rsp_t want;
        if (pending_translations.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, got 0x%0h", $time, got);
            mismatches++;
            return;
        end
        want = pending_translations.pop_front();
        compare_field("tlb_hit", 64'(want.tlb_hit), 64'(got.tlb_hit));
        compare_field("physical_page", 64'(want.physical_page), 64'(got.physical_page));
        compare_field("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
        compare_field("instr_hit_count", 64'(want.instr_hit_count),
                      64'(got.instr_hit_count));
        compare_field("instr_miss_count", 64'(want.instr_miss_count),
                      64'(got.instr_miss_count));
        compare_field("data_hit_count", 64'(want.data_hit_count),
                      64'(got.data_hit_count));
        compare_field("data_miss_count", 64'(want.data_miss_count),
                      64'(got.data_miss_count));
    endfunction

    function int pending();
        return pending_translations.size();
    endfunction

    // Translations that never arrived count as failures.
    function void flag_leftovers();
        if (pending_translations.size() > 0)
        begin
            $display("%0t: missing results: expected %0d more, got 0", $time,
                     pending_translations.size());
            mismatches += pending_translations.size();
        end
    endfunction
endclass

module testbench;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_write;
    logic [fatlb_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [fatlb_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                              req_valid;
    logic                              req_stall;
    fatlb_pkg::req_t                   req_bus;
    logic                              rsp_valid;
    logic                              rsp_stall;
    fatlb_pkg::rsp_t                   rsp_bus;

    tlb_scoreboard          tracker;
    bit                     calm;
    bit                     cur_lp;
    int                     stall_left;
    int unsigned            entry_counts [12] = '{16, 8, 1, 0, 31, 3, 16, 17, 5, 12, 2, 16};

    fully_associative_tlb_lru i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_bus),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_bus)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_gap();
        int roll;
        if (calm)
            return 0;
        roll = int'($urandom_range(0, 99));
        if (roll < 60)
            return 0;
        if (roll < 92)
            return int'($urandom_range(1, 4));
        return int'($urandom_range(10, 60));
    endfunction

    // Send one access; returns just after the falling edge that follows acceptance.
    task automatic send_access(input logic [fatlb_pkg::ADDR_W-1:0] addr,
                               input logic is_data);
        int              gap;
        fatlb_pkg::req_t item;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.virtual_address = addr;
        item.is_data         = is_data;
        req_valid = 1'b1;
        req_bus   = item;
        do
            @(posedge clk);
        while (req_stall);
        tracker.predict_lookup(item);
        @(negedge clk);
    endtask

    // Stop sending and wait until every translation has come back.
    task automatic drain_block();
        int guard;
        guard = 0;
        req_valid = 1'b0;
        while (tracker.pending() > 0 && guard < 5000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (fatlb_pkg::NUM_ENTRIES + 4) @(negedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic reconfigure(input bit lp, input int unsigned count);
        drain_block();
        cfg_write = 1'b1;
        cfg_index = fatlb_pkg::REG_LARGE_PAGES;
        cfg_data  = fatlb_pkg::CFG_DATA_W'(lp);
        @(negedge clk);
        tracker.set_register(fatlb_pkg::REG_LARGE_PAGES, fatlb_pkg::CFG_DATA_W'(lp));
        cfg_index = fatlb_pkg::REG_ENTRIES_IN_USE;
        cfg_data  = fatlb_pkg::CFG_DATA_W'(count);
        @(negedge clk);
        tracker.set_register(fatlb_pkg::REG_ENTRIES_IN_USE, fatlb_pkg::CFG_DATA_W'(count));
        cfg_write = 1'b0;
        cur_lp    = lp;
    endtask

    // Result side: random stall bursts, sampled at the rising edge.
    initial
    begin
        rsp_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall = 1'b0;
                if ($urandom_range(0, 9) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_translation(rsp_bus);
    end

    // Main stimulus.
    initial
    begin
        logic [fatlb_pkg::PAGE_W-1:0] page_pool [$];
        logic [fatlb_pkg::PAGE_W-1:0] vp;
        logic [fatlb_pkg::ADDR_W-1:0] addr;
        logic [31:0]                  off;
        int                           pool_n;
        tracker   = new();
        calm      = 1'b0;
        cur_lp    = 1'b0;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        req_valid = 1'b0;
        req_bus   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: address extremes, both access kinds, hits on offsets.
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_00FF, 1'b1);
        send_access(32'hFFFF_FFFF, 1'b1);
        send_access(32'hFFFF_FF00, 1'b0);
        send_access(32'h8000_0001, 1'b0);
        send_access(32'h7FFF_FFFE, 1'b1);

        // An entry count of zero behaves as a single entry.
        reconfigure(1'b0, 0);
        send_access(32'h0000_0042, 1'b0);
        send_access(32'hABCD_EF12, 1'b1);
        send_access(32'h0000_0000, 1'b0);

        // Large pages with an oversized count; old entries compare raw.
        reconfigure(1'b1, 31);
        send_access(32'h0000_0ABC, 1'b0);
        send_access(32'hFFFF_F123, 1'b1);
        send_access(32'hFFFF_F000, 1'b0);
        send_access(32'h1234_5678, 1'b1);

        // Fill the whole TLB and force one LRU eviction.
        reconfigure(1'b0, 16);
        for (int i = 0; i < 11; i++)
            send_access({8'h40 + 8'(i), 16'h0000, 8'h55}, 1'(i));

        // Random phases over a pool of reused pages.
        for (int phase = 0; phase < 12; phase++)
        begin
            reconfigure((phase < 2) ? 1'(phase) : 1'($urandom_range(0, 1)),
                        entry_counts[phase]);
            calm = (phase % 4 == 3);
            if (phase == 0 || $urandom_range(0, 2) == 0)
            begin
                page_pool.delete();
                pool_n = int'($urandom_range(3, 40));
                repeat (pool_n)
                begin
                    vp = fatlb_pkg::PAGE_W'($urandom);
                    if ($urandom_range(0, 1))
                        vp[23:20] = 4'h0;
                    page_pool.push_back(vp);
                end
            end
            repeat (121)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    vp   = page_pool[$urandom_range(0, page_pool.size() - 1)];
                    off  = $urandom;
                    addr = cur_lp ? {vp[19:0], off[11:0]} : {vp, off[7:0]};
                end
                else
                    addr = $urandom;
                send_access(addr, 1'($urandom_range(0, 1)));
            end
        end

        calm = 1'b0;
        drain_block();
        tracker.flag_leftovers();
        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
design/fatlb_pkg.sv
design/fatlb_cell.sv
design/fully_associative_tlb_lru.sv
dv/testbench.sv
